FILE: rtl/core/ptc_pkg.sv
package ptc_pkg;

	localparam int unsigned DivSteps   = 32;
	localparam int unsigned PtcLatency = 45;

	localparam logic [2:0] CfgT1   = 3'd0;
	localparam logic [2:0] CfgT2   = 3'd1;
	localparam logic [2:0] CfgT3   = 3'd2;
	localparam logic [2:0] CfgP1   = 3'd3;
	localparam logic [2:0] CfgP2P5 = 3'd4;
	localparam logic [2:0] CfgP6P9 = 3'd5;

	localparam logic [31:0] PressOffset = 32'd64000;
	localparam logic [31:0] PressBase   = 32'd1048576;
	localparam logic [31:0] PressScale  = 32'd3125;
	localparam logic [31:0] DenBias     = 32'd32768;
	localparam logic [31:0] TempRound   = 32'd128;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} ptc_in_t;

	typedef struct packed {
		logic signed [15:0] temperature_centi;
		logic [31:0]        pressure_pa;
		logic               pressure_valid;
	} ptc_out_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [63:0] p2_to_p5;
		logic [63:0] p6_to_p9;
	} ptc_cal_t;

	typedef struct packed {
		logic signed [15:0] temp;
		logic               ok;
	} ptc_side_t;

	function automatic logic signed [31:0] sx16(input logic [15:0] w);
		return {{16{w[15]}}, w};
	endfunction

endpackage

FILE: rtl/core/pressure_temp_compensation.sv
// Barometric compensation, 32-bit integer form.
// Calibration: write cfg_data to register cfg_index while cfg_we is high:
//   0 T1, 1 T2, 2 T3, 3 P1, 4 P2..P5 packed, 5 P6..P9 packed (word low first).
//   Only write while no word is in flight.
// Input: a raw temperature/pressure word is taken at each edge with start high
//   and busy low; busy is always low, so one word every cycle.
// Output: done is high for one cycle with the result word; each word passes
//   the front stages, the 32-step restoring divider and the post stages.
// Throughput: one word per cycle.
// pressure_valid is low and pressure_pa zero when the divisor is zero.
// Reset clears calibration to zero and empties the pipeline; no done follows.
// The receiver cannot stall: every done word must be taken.
module pressure_temp_compensation (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ptc_pkg::ptc_in_t  sample,
	output logic              done,
	output ptc_pkg::ptc_out_t result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import ptc_pkg::*;

	ptc_cal_t  cal_q;
	logic      f_vld, d_vld, scl;
	logic [31:0] num, den, quo;
	ptc_side_t f_side, d_side;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgT1:   cal_q.t1 <= cfg_data[15:0];
				CfgT2:   cal_q.t2 <= cfg_data[15:0];
				CfgT3:   cal_q.t3 <= cfg_data[15:0];
				CfgP1:   cal_q.p1 <= cfg_data[15:0];
				CfgP2P5: cal_q.p2_to_p5 <= cfg_data;
				CfgP6P9: cal_q.p6_to_p9 <= cfg_data;
				default: ;
			endcase
		end
	end

	ptc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start & ~busy),
		.sample  (sample),
		.cal     (cal_q),
		.out_vld (f_vld),
		.num     (num),
		.den     (den),
		.side    (f_side)
	);

	ptc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (f_vld),
		.num      (num),
		.den      (den),
		.side_in  (f_side),
		.out_vld  (d_vld),
		.quo      (quo),
		.scl      (scl),
		.side_out (d_side)
	);

	ptc_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (d_vld),
		.quo      (quo),
		.scl      (scl),
		.side     (d_side),
		.p6_to_p9 (cal_q.p6_to_p9),
		.done     (done),
		.result   (result)
	);

	a_lat_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PtcLatency done)
		else $error("result word missing");

	a_lat_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##PtcLatency !done)
		else $error("spurious result word");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.pressure_valid) |-> (result.pressure_pa == '0))
		else $error("pressure not cleared on zero divisor");

endmodule

FILE: rtl/core/ptc_front.sv
module ptc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  ptc_pkg::ptc_in_t  sample,
	input  ptc_pkg::ptc_cal_t cal,
	output logic              out_vld,
	output logic [31:0]       num,
	output logic [31:0]       den,
	output ptc_pkg::ptc_side_t side
);
	import ptc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [31:0] atp_s1, dd_s1, at_s2, bt_s2, fine_s3, pa_s4;
	logic signed [31:0] sq_s5, ap5_s5, p2a_s5, b6_s6, p3s_s6, ap5_s6, p2a_s6;
	logic signed [31:0] b_s7, ad_s7, den_s8, num_s8;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7;
	logic signed [15:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;

	logic signed [31:0] ta, d, tq, q, bsum, pb;
	logic signed [31:0] p2, p3, p4, p5, p6;

	assign p2 = sx16(cal.p2_to_p5[15:0]);
	assign p3 = sx16(cal.p2_to_p5[31:16]);
	assign p4 = sx16(cal.p2_to_p5[47:32]);
	assign p5 = sx16(cal.p2_to_p5[63:48]);
	assign p6 = sx16(cal.p6_to_p9[15:0]);

	always_comb begin
		ta   = $signed({15'd0, sample.raw_temperature[19:3]} - {15'd0, cal.t1, 1'b0});
		d    = $signed({16'd0, sample.raw_temperature[19:4]} - {16'd0, cal.t1});
		tq   = ((fine_s3 <<< 2) + fine_s3 + $signed(TempRound)) >>> 8;
		q    = pa_s4 >>> 2;
		bsum = b6_s6 + (ap5_s6 <<< 1);
		pb   = $signed(PressBase - {12'd0, adcp_s7});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
		end else begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <=
				{in_vld, vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7};
		end
	end

	always_ff @(posedge clk) begin
		atp_s1  <= ta * sx16(cal.t2);
		dd_s1   <= d * d;
		adcp_s1 <= sample.raw_pressure;

		at_s2   <= atp_s1 >>> 11;
		bt_s2   <= (dd_s1 >>> 12) * sx16(cal.t3);
		adcp_s2 <= adcp_s1;

		fine_s3 <= at_s2 + (bt_s2 >>> 14);
		adcp_s3 <= adcp_s2;

		if (tq > 32'sd32767)
			temp_s4 <= 16'sh7fff;
		else if (tq < -32'sd32768)
			temp_s4 <= -16'sh8000;
		else
			temp_s4 <= tq[15:0];
		pa_s4   <= (fine_s3 >>> 1) - $signed(PressOffset);
		adcp_s4 <= adcp_s3;

		sq_s5   <= q * q;
		ap5_s5  <= pa_s4 * p5;
		p2a_s5  <= p2 * pa_s4;
		temp_s5 <= temp_s4;
		adcp_s5 <= adcp_s4;

		b6_s6   <= (sq_s5 >>> 11) * p6;
		p3s_s6  <= p3 * (sq_s5 >>> 13);
		ap5_s6  <= ap5_s5;
		p2a_s6  <= p2a_s5;
		temp_s6 <= temp_s5;
		adcp_s6 <= adcp_s5;

		b_s7    <= (bsum >>> 2) + (p4 <<< 16);
		ad_s7   <= ((p3s_s6 >>> 3) + (p2a_s6 >>> 1)) >>> 18;
		temp_s7 <= temp_s6;
		adcp_s7 <= adcp_s6;

		den_s8  <= ((ad_s7 + $signed(DenBias)) * $signed({16'd0, cal.p1})) >>> 15;
		num_s8  <= (pb - (b_s7 >>> 12)) * $signed(PressScale);
		temp_s8 <= temp_s7;
	end

	assign out_vld   = vld_s8;
	assign num       = num_s8;
	assign den       = den_s8;
	assign side.temp = temp_s8;
	assign side.ok   = (den_s8 != 32'sd0);

endmodule

FILE: rtl/core/ptc_div.sv
module ptc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [31:0]        num,
	input  logic [31:0]        den,
	input  ptc_pkg::ptc_side_t side_in,
	output logic               out_vld,
	output logic [31:0]        quo,
	output logic               scl,
	output ptc_pkg::ptc_side_t side_out
);
	import ptc_pkg::*;

	logic [31:0] rem_s [0:DivSteps];
	logic [31:0] dq_s  [0:DivSteps];
	logic [31:0] den_s [0:DivSteps];
	logic        scl_s [0:DivSteps];
	logic        vld_s [0:DivSteps];
	ptc_side_t   side_s [0:DivSteps];

	// top bit set: divide as is and double; else double the dividend first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else
			vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		dq_s[0]   <= num[31] ? num : {num[30:0], 1'b0};
		den_s[0]  <= den;
		scl_s[0]  <= num[31];
		side_s[0] <= side_in;
	end

	for (genvar k = 0; k < DivSteps; k++) begin : g_step
		logic [32:0] tr;
		logic        ge;

		assign tr = {rem_s[k], dq_s[k][31]};
		assign ge = (tr >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? 32'(tr - {1'b0, den_s[k]}) : tr[31:0];
			dq_s[k+1]   <= {dq_s[k][30:0], ge};
			den_s[k+1]  <= den_s[k];
			scl_s[k+1]  <= scl_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld  = vld_s[DivSteps];
	assign quo      = dq_s[DivSteps];
	assign scl      = scl_s[DivSteps];
	assign side_out = side_s[DivSteps];

endmodule

FILE: rtl/core/ptc_post.sv
module ptc_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [31:0]        quo,
	input  logic               scl,
	input  ptc_pkg::ptc_side_t side,
	input  logic [63:0]        p6_to_p9,
	output logic               done,
	output ptc_pkg::ptc_out_t  result
);
	import ptc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [31:0] p_s1, p_s2, p_s3;
	logic [31:0] qq_s2, pp8_s2;
	logic signed [31:0] a9_s3, b8_s3;
	ptc_side_t side_s1, side_s2, side_s3;
	ptc_out_t res_s4;

	logic [31:0] q;
	logic signed [31:0] p7, p8, p9, corr;

	assign p7 = sx16(p6_to_p9[31:16]);
	assign p8 = sx16(p6_to_p9[47:32]);
	assign p9 = sx16(p6_to_p9[63:48]);

	always_comb begin
		q    = p_s1 >> 3;
		corr = (a9_s3 + b8_s3 + p7) >>> 4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			{vld_s1, vld_s2, vld_s3, vld_s4} <= '0;
		else
			{vld_s1, vld_s2, vld_s3, vld_s4} <= {in_vld, vld_s1, vld_s2, vld_s3};
	end

	always_ff @(posedge clk) begin
		p_s1    <= scl ? {quo[30:0], 1'b0} : quo;
		side_s1 <= side;

		qq_s2   <= q * q;
		pp8_s2  <= (p_s1 >> 2) * p8;
		p_s2    <= p_s1;
		side_s2 <= side_s1;

		a9_s3   <= (p9 * $signed(qq_s2 >> 13)) >>> 12;
		b8_s3   <= $signed(pp8_s2) >>> 13;
		p_s3    <= p_s2;
		side_s3 <= side_s2;

		res_s4.temperature_centi <= side_s3.temp;
		res_s4.pressure_pa       <= side_s3.ok ? p_s3 + corr : '0;
		res_s4.pressure_valid    <= side_s3.ok;
	end

	assign done   = vld_s4;
	assign result = res_s4;

endmodule
